@@ rtl/core/tms_pkg.sv @@
// Shared constants and types of the trimmed mean stream unit.
package tms_pkg;

    localparam int MAX_DROP_DEF      = 10;
    localparam int SAMPLE_BITS_DEF   = 32;
    localparam int COUNT_BITS_DEF    = 24;
    localparam int FRACTION_BITS_DEF = 20;

    // configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DROP_HIGH = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DROP_LOW  = 1'd1;

    // per-cycle command to every cell of a list
    typedef struct packed {
        logic ins;
        logic shift;
        logic clr;
    } t_cell_ctl;

endpackage

@@ rtl/core/tms_cell.sv @@
// One entry of an ascending sorted list with shift-insertion and drain shift.
module tms_cell #(
    parameter int SAMPLE_BITS = tms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tms_pkg::t_cell_ctl     i_ctl,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [SAMPLE_BITS-1:0] i_left_val,
    input  logic                   i_left_vld,
    input  logic                   i_left_take,
    input  logic [SAMPLE_BITS-1:0] i_right_val,
    input  logic                   i_right_vld,
    output logic [SAMPLE_BITS-1:0] o_val,
    output logic                   o_vld,
    output logic                   o_take
);

    logic [SAMPLE_BITS-1:0] r_val, n_val;
    logic                   r_vld, n_vld;

    // new sample lands here or further left
    assign o_take = !r_vld || (i_sample <= r_val);

    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        if (i_ctl.clr) begin
            n_vld = 1'b0;
        end else if (i_ctl.ins) begin
            if (o_take) begin
                if (i_left_take) begin
                    n_val = i_left_val;
                    n_vld = i_left_vld;
                end else begin
                    n_val = i_sample;
                    n_vld = 1'b1;
                end
            end
        end else if (i_ctl.shift) begin
            n_val = i_right_val;
            n_vld = i_right_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_vld = r_vld;

endmodule

@@ rtl/core/tms_chain.sv @@
// Row of list cells: inserts flow rightward, drain shifts toward the head.
module tms_chain #(
    parameter int MAX_DROP    = tms_pkg::MAX_DROP_DEF,
    parameter int SAMPLE_BITS = tms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tms_pkg::t_cell_ctl     i_ctl,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic [SAMPLE_BITS-1:0] o_head
);

    logic [SAMPLE_BITS-1:0] w_val  [MAX_DROP];
    logic                   w_vld  [MAX_DROP];
    logic                   w_take [MAX_DROP];

    for (genvar g = 0; g < MAX_DROP; g++) begin : g_cell
        logic [SAMPLE_BITS-1:0] w_lval, w_rval;
        logic                   w_lvld, w_ltake, w_rvld;

        if (g == 0) begin : g_first
            assign w_lval  = i_sample;
            assign w_lvld  = 1'b0;
            assign w_ltake = 1'b0;
        end else begin : g_mid
            assign w_lval  = w_val[g-1];
            assign w_lvld  = w_vld[g-1];
            assign w_ltake = w_take[g-1];
        end

        if (g == MAX_DROP - 1) begin : g_last
            assign w_rval = i_sample;
            assign w_rvld = 1'b0;
        end else begin : g_body
            assign w_rval = w_val[g+1];
            assign w_rvld = w_vld[g+1];
        end

        tms_cell #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (i_ctl),
            .i_sample   (i_sample),
            .i_left_val (w_lval),
            .i_left_vld (w_lvld),
            .i_left_take(w_ltake),
            .i_right_val(w_rval),
            .i_right_vld(w_rvld),
            .o_val      (w_val[g]),
            .o_vld      (w_vld[g]),
            .o_take     (w_take[g])
        );
    end

    assign o_head = w_val[0];

endmodule

@@ rtl/core/tms_div.sv @@
// Restoring divider, one quotient bit per cycle, for the fixed point mean.
module tms_div #(
    parameter int SAMPLE_BITS   = tms_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS    = tms_pkg::COUNT_BITS_DEF,
    parameter int FRACTION_BITS = tms_pkg::FRACTION_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [SAMPLE_BITS+COUNT_BITS-1:0]    i_dividend,
    input  logic [COUNT_BITS-1:0]                i_divisor,
    output logic                                 o_done,
    output logic [SAMPLE_BITS+FRACTION_BITS-1:0] o_quot
);

    localparam int QW = SAMPLE_BITS + FRACTION_BITS;
    localparam int CW = $clog2(QW + 1);

    logic [COUNT_BITS-1:0] r_rem, r_div;
    logic [QW-1:0]         r_nq;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy, r_done;
    logic [COUNT_BITS:0]   w_trial;
    logic                  w_fit;

    // quotient is known to fit QW bits, so the top dividend bits seed the remainder
    assign w_trial = {r_rem, r_nq[QW-1]};
    assign w_fit   = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_rem <= i_dividend[SAMPLE_BITS+COUNT_BITS-1:SAMPLE_BITS];
            r_div <= i_divisor;
            r_nq  <= QW'(i_dividend[SAMPLE_BITS-1:0]) << FRACTION_BITS;
        end else if (r_busy) begin
            r_rem <= w_fit ? COUNT_BITS'(w_trial - {1'b0, r_div})
                           : COUNT_BITS'(w_trial);
            r_nq  <= {r_nq[QW-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_nq;

endmodule

@@ rtl/core/trimmed_mean_stream_unit.sv @@
// Top level of the trimmed mean stream unit: counters, list control, divider, result register.
//
//  channel   direction  flow control        payload
//  sample    in         i_valid / o_stall   i_sample, i_last
//  result    out        o_valid / i_stall   o_trimmed_sum, o_kept_count, o_mean_whole,
//                                           o_mean_fraction, o_error
//  config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// Samples are taken one per cycle while o_stall is low. After a last-marked word the
// unit drains the two lists, runs the divider (skipped on error) and then posts the
// result; o_stall is high over that span. The result register frees the input side,
// so a held result only delays the next stream's final result.
// Reset clears the lists, counters and drop registers.
module trimmed_mean_stream_unit #(
    parameter int MAX_DROP      = tms_pkg::MAX_DROP_DEF,
    parameter int SAMPLE_BITS   = tms_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS    = tms_pkg::COUNT_BITS_DEF,
    parameter int FRACTION_BITS = tms_pkg::FRACTION_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_stall,
    input  logic [SAMPLE_BITS-1:0]                    i_sample,
    input  logic                                      i_last,
    output logic                                      o_valid,
    input  logic                                      i_stall,
    output logic [SAMPLE_BITS+COUNT_BITS-1:0]         o_trimmed_sum,
    output logic [COUNT_BITS-1:0]                     o_kept_count,
    output logic [SAMPLE_BITS-1:0]                    o_mean_whole,
    output logic [((FRACTION_BITS > 0) ? FRACTION_BITS : 1)-1:0] o_mean_fraction,
    output logic                                      o_error,
    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  logic [tms_pkg::CFG_INDEX_BITS-1:0]        i_cfg_index,
    input  logic [tms_pkg::CFG_DATA_BITS-1:0]         i_cfg_data
);

    localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
    localparam int QW       = SAMPLE_BITS + FRACTION_BITS;
    localparam int FW       = (FRACTION_BITS > 0) ? FRACTION_BITS : 1;
    localparam int DW       = $clog2(MAX_DROP + 1);
    localparam int CMPW     = DW + tms_pkg::CFG_DATA_BITS;
    localparam int KW       = COUNT_BITS + DW + 1;

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_DRAIN = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_HOLD  = 2'd3;

    logic [1:0]                        r_state;
    logic [tms_pkg::CFG_DATA_BITS-1:0] r_drop_high, r_drop_low;
    logic [SUM_BITS-1:0]               r_sum, r_drop;
    logic [COUNT_BITS-1:0]             r_count;
    logic                              r_sat;
    logic [DW-1:0]                     r_dcnt;

    logic [SUM_BITS-1:0]    r_res_sum;
    logic [COUNT_BITS-1:0]  r_res_kept;
    logic [SAMPLE_BITS-1:0] r_res_whole;
    logic [FW-1:0]          r_res_frac;
    logic                   r_res_err;

    logic                   r_out_valid;
    logic [SUM_BITS-1:0]    r_out_sum;
    logic [COUNT_BITS-1:0]  r_out_kept;
    logic [SAMPLE_BITS-1:0] r_out_whole;
    logic [FW-1:0]          r_out_frac;
    logic                   r_out_err;

    logic                   w_acc, w_upd, w_out_free;
    logic [DW-1:0]          w_dl, w_dh;
    logic                   w_err, w_drain_done;
    logic [SUM_BITS-1:0]    w_tsum;
    logic [COUNT_BITS-1:0]  w_kept;
    logic [SAMPLE_BITS-1:0] w_small_head, w_large_head, w_large_inv;
    logic                   w_div_start, w_div_done;
    logic [QW-1:0]          w_quot;
    logic [FW-1:0]          w_frac;
    tms_pkg::t_cell_ctl     w_ctl;

    assign o_stall     = (r_state != ST_RUN);
    assign w_acc       = i_valid && !o_stall;
    assign w_upd       = w_acc && !r_sat && !(&r_count);
    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || !i_stall;

    // drop counts above the list depth act as the depth
    assign w_dl = (CMPW'(r_drop_low) > CMPW'(MAX_DROP)) ? DW'(MAX_DROP) : DW'(r_drop_low);
    assign w_dh = (CMPW'(r_drop_high) > CMPW'(MAX_DROP)) ? DW'(MAX_DROP) : DW'(r_drop_high);

    assign w_err        = r_sat || (KW'(r_count) <= (KW'(w_dl) + KW'(w_dh)));
    assign w_drain_done = (r_dcnt >= w_dl) && (r_dcnt >= w_dh);
    assign w_tsum       = r_sum - r_drop;
    assign w_kept       = r_count - COUNT_BITS'(w_dl) - COUNT_BITS'(w_dh);
    assign w_div_start  = (r_state == ST_DRAIN) && w_drain_done && !w_err;
    assign w_large_head = ~w_large_inv;

    always_comb begin
        w_ctl.ins   = w_upd;
        w_ctl.shift = (r_state == ST_DRAIN) && !w_drain_done;
        w_ctl.clr   = (r_state == ST_DRAIN) && w_drain_done;
    end

    tms_chain #(
        .MAX_DROP   (MAX_DROP),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_small (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_sample(i_sample),
        .o_head  (w_small_head)
    );

    // largest list keeps inverted samples, so ascending order there is descending here
    tms_chain #(
        .MAX_DROP   (MAX_DROP),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_large (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_sample(~i_sample),
        .o_head  (w_large_inv)
    );

    tms_div #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .COUNT_BITS   (COUNT_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_dividend(w_tsum),
        .i_divisor (w_kept),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    if (FRACTION_BITS > 0) begin : g_frac
        assign w_frac = w_quot[FW-1:0];
    end else begin : g_nofrac
        assign w_frac = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_drop_high <= '0;
            r_drop_low  <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    tms_pkg::CFG_DROP_HIGH: r_drop_high <= i_cfg_data;
                    tms_pkg::CFG_DROP_LOW:  r_drop_low  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_state == ST_HOLD && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_RUN: begin
                    if (w_acc && !r_sat && (&r_count)) begin
                        r_sat <= 1'b1;
                    end
                    if (w_upd) begin
                        r_sum   <= r_sum + SUM_BITS'(i_sample);
                        r_count <= r_count + COUNT_BITS'(1);
                    end
                    if (w_acc && i_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (w_drain_done) begin
                        r_sum   <= '0;
                        r_count <= '0;
                        r_sat   <= 1'b0;
                        r_state <= w_err ? ST_HOLD : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_state <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (w_out_free) begin
                        r_state <= ST_RUN;
                    end
                end
                default: r_state <= ST_RUN;
            endcase
        end

        // payload registers
        if (w_acc && i_last) begin
            r_dcnt <= '0;
            r_drop <= '0;
        end else if (r_state == ST_DRAIN && !w_drain_done) begin
            r_dcnt <= r_dcnt + DW'(1);
            r_drop <= r_drop
                    + ((r_dcnt < w_dl) ? SUM_BITS'(w_small_head) : SUM_BITS'(0))
                    + ((r_dcnt < w_dh) ? SUM_BITS'(w_large_head) : SUM_BITS'(0));
        end

        if (r_state == ST_DRAIN && w_drain_done) begin
            r_res_err   <= w_err;
            r_res_sum   <= w_err ? '0 : w_tsum;
            r_res_kept  <= w_err ? '0 : w_kept;
            r_res_whole <= '0;
            r_res_frac  <= '0;
        end else if (r_state == ST_DIV && w_div_done) begin
            r_res_whole <= w_quot[QW-1:FRACTION_BITS];
            r_res_frac  <= w_frac;
        end

        if (r_state == ST_HOLD && w_out_free) begin
            r_out_sum   <= r_res_sum;
            r_out_kept  <= r_res_kept;
            r_out_whole <= r_res_whole;
            r_out_frac  <= r_res_frac;
            r_out_err   <= r_res_err;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_trimmed_sum   = r_out_sum;
    assign o_kept_count    = r_out_kept;
    assign o_mean_whole    = r_out_whole;
    assign o_mean_fraction = r_out_frac;
    assign o_error         = r_out_err;

endmodule
